FILE: design/wmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmm_pkg
// Shared types and constants of the Winograd inner-product matrix multiplier.
// ----------------------------------------------------------------------------
package wmm_pkg;

  // default store dimension (elements per row and per column)
  localparam int MAX_DIM_DEF = 8;

  // element and result width
  localparam int DATA_W = 32;

  // counter widths for the (at most 8) rows, columns and pair index
  localparam int IDX_W  = 3;
  localparam int PAIR_W = 2;

  // input item opcodes
  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // register indexes of the configuration port
  localparam logic [1:0] REG_ROW_COUNT   = 2'd0;
  localparam logic [1:0] REG_INNER_COUNT = 2'd1;
  localparam logic [1:0] REG_COL_COUNT   = 2'd2;

  // kind of term moving through the shared multiplier
  typedef enum logic [1:0] {
    TERM_ROWF = 2'd0,  // a[i][2k] * a[i][2k+1]
    TERM_COLF = 2'd1,  // b[2k][j] * b[2k+1][j]
    TERM_PAIR = 2'd2,  // (a[i][2k] + b[2k+1][j]) * (a[i][2k+1] + b[2k][j])
    TERM_ODD  = 2'd3   // a[i][n-1] * b[n-1][j]
  } term_kind_t;

  // control tag carried with each term through the pipeline
  typedef struct packed {
    logic               v;        // stage holds a term
    term_kind_t         kind;
    logic               zero;     // factor with no pairs: term contributes zero
    logic               first;    // first term of a sum
    logic               lastt;    // last term of a sum
    logic               run_end;  // last product element of the run
    logic [IDX_W-1:0]   i;
    logic [IDX_W-1:0]   j;
  } term_ctl_t;

  // finished product element leaving the datapath
  typedef struct packed {
    logic               v;
    logic [IDX_W-1:0]   i;
    logic [IDX_W-1:0]   j;
    logic               run_end;
    logic [DATA_W-1:0]  value;
  } wmm_res_t;

endpackage

FILE: design/winograd_matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// winograd_matrix_multiply
// Integer matrix product by Winograd's inner-product method, one shared
// multiplier under a small sequencer.
// ----------------------------------------------------------------------------
// Usage
//   Input stream (s_axis_*): each transfer is one item. op 0 writes A[row][col],
//   op 1 writes B[row][col] (ignored when row or col is not below MAX_DIM),
//   op 2 computes the product, op 3 is ignored.
//   Output stream (m_axis_*): one transfer per product element, row-major,
//   tlast on the final one. The APB port sets row, inner and column counts
//   (0 acts as 1, values above min(MAX_DIM, 8) act as that limit).
//   Timing of a compute: unless the output stalls, one term per cycle enters
//   the shared multiplier: nr*f + nc*f row/column factor terms (f = max(n/2, 1)),
//   a drain until the pipeline is empty so the factors land, then nr*nc*ceil(n/2)
//   product terms. The input is not ready while the sequencer runs, and takes a
//   new item once the last term has issued.
//   Reset clears control state and sets all counts to 8; the element stores
//   are not cleared, so only written elements may be used.
//   When a finished element meets a full output register that the receiver
//   stalls, the multiplier pipeline and the sequencer hold until the result is taken.
// ----------------------------------------------------------------------------
module winograd_matrix_multiply #(
  parameter int MAX_DIM = wmm_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // op[1:0], row[4:2], col[7:5], value[39:8]
  // product elements
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_row[2:0], out_col[5:3], result[37:6], zero fill
  output logic        m_axis_tlast,   // last
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wmm_pkg::*;

  localparam int DEPTH     = MAX_DIM * MAX_DIM;
  localparam int AW        = $clog2(DEPTH);
  localparam int DIM_LIMIT = (MAX_DIM < 8) ? MAX_DIM : 8;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ROWF  = 5'b00010,
    ST_COLF  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_MAIN  = 5'b10000
  } state_t;

  function automatic logic [3:0] clamp_dim(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) begin
      r = 4'd1;
    end else if (32'(v) > DIM_LIMIT) begin
      r = 4'(DIM_LIMIT);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] elem_addr(input logic [IDX_W-1:0] r,
                                              input logic [IDX_W-1:0] c);
    return AW'(r) * AW'(MAX_DIM) + AW'(c);
  endfunction

  // configuration registers
  logic [3:0] row_count, inner_count, col_count;
  logic       cfg_wr;

  // input fields
  logic [1:0]        in_op;
  logic [2:0]        in_row, in_col;
  logic [DATA_W-1:0] in_value;
  logic              in_xfer, in_ok, wr_a, wr_b;

  // sequencer
  state_t            state, state_next;
  logic [IDX_W-1:0]  i, i_next, j, j_next;
  logic [PAIR_W-1:0] k, k_next;
  term_ctl_t         issue;
  logic [3:0]        nr, ni, nc;
  logic [2:0]        half, nterm_f, nterm_m;
  logic [4:0]        ni_up;
  logic              i_last, j_last, kf_last, km_last, odd_term;

  // stores and datapath
  logic [DATA_W-1:0] a_store [DEPTH];
  logic [DATA_W-1:0] b_store [DEPTH];
  logic [DATA_W-1:0] a0, a1, b0, b1;
  logic [AW-1:0]     ra0, ra1, rb0, rb1;
  wmm_res_t          res;
  logic              busy, adv;

  // ------------------------------------------------------------------
  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= 4'd8;
      inner_count <= 4'd8;
      col_count   <= 4'd8;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ROW_COUNT:   row_count   <= pwdata[3:0];
        REG_INNER_COUNT: inner_count <= pwdata[3:0];
        REG_COL_COUNT:   col_count   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROW_COUNT:   prdata = {28'd0, row_count};
      REG_INNER_COUNT: prdata = {28'd0, inner_count};
      REG_COL_COUNT:   prdata = {28'd0, col_count};
      default:         prdata = 32'd0;
    endcase
  end

  // ------------------------------------------------------------------
  // input decode
  assign in_op    = s_axis_tdata[1:0];
  assign in_row   = s_axis_tdata[4:2];
  assign in_col   = s_axis_tdata[7:5];
  assign in_value = s_axis_tdata[39:8];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign in_ok         = (32'(in_row) < MAX_DIM) && (32'(in_col) < MAX_DIM);
  assign wr_a          = in_xfer && in_ok && (in_op == OP_LOAD_A);
  assign wr_b          = in_xfer && in_ok && (in_op == OP_LOAD_B);

  // ------------------------------------------------------------------
  // dimensions and loop limits
  assign nr      = clamp_dim(row_count);
  assign ni      = clamp_dim(inner_count);
  assign nc      = clamp_dim(col_count);
  assign half    = ni[3:1];
  assign nterm_f = (half == 3'd0) ? 3'd1 : half;
  assign ni_up   = {1'b0, ni} + 5'd1;
  assign nterm_m = ni_up[3:1];

  assign i_last   = ({1'b0, i} == nr - 4'd1);
  assign j_last   = ({1'b0, j} == nc - 4'd1);
  assign kf_last  = ({1'b0, k} == nterm_f - 3'd1);
  assign km_last  = ({1'b0, k} == nterm_m - 3'd1);
  assign odd_term = ni[0] && ({1'b0, k} == half);

  // stall only when a finished element meets a full, unaccepted output
  assign adv = !(res.v && m_axis_tvalid && !m_axis_tready);

  // ------------------------------------------------------------------
  // sequencer: one term per cycle into the shared multiplier while the pipeline advances
  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    issue      = '0;
    issue.i    = i;
    issue.j    = j;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && in_op == OP_COMPUTE) begin
          state_next = ST_ROWF;
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
        end
      end
      ST_ROWF: begin
        if (adv) begin
          issue.v     = 1'b1;
          issue.kind  = TERM_ROWF;
          issue.zero  = (half == 3'd0);
          issue.first = (k == '0);
          issue.lastt = kf_last;
          if (kf_last) begin
            k_next = '0;
            if (i_last) begin
              i_next     = '0;
              state_next = ST_COLF;
            end else begin
              i_next = i + 1'b1;
            end
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      ST_COLF: begin
        if (adv) begin
          issue.v     = 1'b1;
          issue.kind  = TERM_COLF;
          issue.zero  = (half == 3'd0);
          issue.first = (k == '0);
          issue.lastt = kf_last;
          if (kf_last) begin
            k_next = '0;
            if (j_last) begin
              j_next     = '0;
              state_next = ST_DRAIN;
            end else begin
              j_next = j + 1'b1;
            end
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        // factors must be written back before the product terms read them
        if (!busy) begin
          state_next = ST_MAIN;
        end
      end
      ST_MAIN: begin
        if (adv) begin
          issue.v       = 1'b1;
          issue.kind    = odd_term ? TERM_ODD : TERM_PAIR;
          issue.first   = (k == '0);
          issue.lastt   = km_last;
          issue.run_end = i_last && j_last;
          if (km_last) begin
            k_next = '0;
            if (j_last) begin
              j_next = '0;
              if (i_last) begin
                i_next     = '0;
                state_next = ST_IDLE;
              end else begin
                i_next = i + 1'b1;
              end
            end else begin
              j_next = j + 1'b1;
            end
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  // ------------------------------------------------------------------
  // element stores: one write port, two registered read ports each
  assign ra0 = elem_addr(i, {k, 1'b0});
  assign ra1 = elem_addr(i, {k, 1'b1});
  assign rb0 = elem_addr({k, 1'b0}, j);
  assign rb1 = elem_addr({k, 1'b1}, j);

  always_ff @(posedge clk) begin
    if (wr_a) begin
      a_store[elem_addr(in_row, in_col)] <= in_value;
    end
    if (adv) begin
      a0 <= a_store[ra0];
      a1 <= a_store[ra1];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      b_store[elem_addr(in_row, in_col)] <= in_value;
    end
    if (adv) begin
      b0 <= b_store[rb0];
      b1 <= b_store[rb1];
    end
  end

  // ------------------------------------------------------------------
  // shared multiply-accumulate datapath
  wmm_datapath u_datapath (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .issue (issue),
    .a0    (a0),
    .a1    (a1),
    .b0    (b0),
    .b1    (b1),
    .res   (res),
    .busy  (busy)
  );

  // ------------------------------------------------------------------
  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv && res.v) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.v) begin
      m_axis_tdata <= {2'b00, res.value, res.j, res.i};
      m_axis_tlast <= res.run_end;
    end
  end

endmodule

FILE: design/wmm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmm_datapath
// Operand forming, shared 32x32 multiplier and accumulator; holds the row
// and column factors and delivers finished product elements.
// ----------------------------------------------------------------------------
module wmm_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,       // whole pipeline moves on
  input  wmm_pkg::term_ctl_t       issue,     // term whose store reads are in flight
  input  logic [wmm_pkg::DATA_W-1:0] a0,      // registered store read data
  input  logic [wmm_pkg::DATA_W-1:0] a1,
  input  logic [wmm_pkg::DATA_W-1:0] b0,
  input  logic [wmm_pkg::DATA_W-1:0] b1,
  output wmm_pkg::wmm_res_t        res,
  output logic                     busy
);
  import wmm_pkg::*;

  term_ctl_t         s1, s2, s3;
  logic [DATA_W-1:0] x1, y1, fsum1;
  logic [DATA_W-1:0] x2, y2, fsum2;
  logic [DATA_W-1:0] prod3, base3;
  logic [DATA_W-1:0] acc, acc_next;
  logic [DATA_W-1:0] row_factors [8];
  logic [DATA_W-1:0] col_factors [8];

  // control tags, one per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
    end else if (adv) begin
      s1 <= issue;
      s2 <= s1;
      s3 <= s2;
    end
  end

  // stage 1: operand forming and factor sum
  always_comb begin
    x1 = a0;
    y1 = a1;
    case (s1.kind)
      TERM_ROWF: begin
        x1 = a0;
        y1 = a1;
      end
      TERM_COLF: begin
        x1 = b0;
        y1 = b1;
      end
      TERM_PAIR: begin
        x1 = a0 + b1;
        y1 = a1 + b0;
      end
      TERM_ODD: begin
        x1 = a0;
        y1 = b0;
      end
      default: begin
        x1 = a0;
        y1 = a1;
      end
    endcase
    // no pairs: neither operand is a live element
    if (s1.zero) begin
      x1 = '0;
      y1 = '0;
    end
    fsum1 = row_factors[s1.i] + col_factors[s1.j];
  end

  // stage 2 and 3 registers: operands, then product and sum start value
  always_ff @(posedge clk) begin
    if (adv) begin
      x2    <= x1;
      y2    <= y1;
      fsum2 <= fsum1;
      prod3 <= x2 * y2;
      base3 <= (s2.kind == TERM_PAIR || s2.kind == TERM_ODD) ? ('0 - fsum2) : '0;
    end
  end

  // stage 3: accumulate
  assign acc_next = (s3.first ? base3 : acc) + prod3;

  always_ff @(posedge clk) begin
    if (adv && s3.v) begin
      acc <= acc_next;
      if (s3.lastt && s3.kind == TERM_ROWF) begin
        row_factors[s3.i] <= acc_next;
      end
      if (s3.lastt && s3.kind == TERM_COLF) begin
        col_factors[s3.j] <= acc_next;
      end
    end
  end

  // finished product element
  always_comb begin
    res.v       = s3.v && s3.lastt && (s3.kind == TERM_PAIR || s3.kind == TERM_ODD);
    res.i       = s3.i;
    res.j       = s3.j;
    res.run_end = s3.run_end;
    res.value   = acc_next;
  end

  assign busy = s1.v || s2.v || s3.v;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Winograd inner-product matrix multiplier.
// Loads elements of A and B over the input stream, sets the three dimension
// registers over APB between computes, and checks every product element
// against a predictor that keeps its own copy of the stores and registers.
// ----------------------------------------------------------------------------
module tb;
  import wmm_pkg::*;

  // no-transfer cycles before the run is declared hung
  localparam int STALL_LIMIT = 4000;
  // receiver hold-off used to back the block up
  localparam int HOLD_CYCLES = 400;
  // opcode that the block ignores
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    bit [2:0]  r;
    bit [2:0]  c;
    bit [31:0] v;
    bit        last;
  } product_t;

  // scoreboard: predicted product elements for every accepted compute
  class wmm_scoreboard;
    bit [31:0] a_mem [64];
    bit [31:0] b_mem [64];
    bit [31:0] row_fac [8];
    bit [31:0] col_fac [8];
    bit [3:0]  dim_reg [3];
    product_t  exp_q [$];
    int        errors;
    int        checked;

    function new();
      dim_reg[REG_ROW_COUNT]   = 4'd8;
      dim_reg[REG_INNER_COUNT] = 4'd8;
      dim_reg[REG_COL_COUNT]   = 4'd8;
      errors  = 0;
      checked = 0;
    endfunction

    // effective dimension: zero acts as one, above eight acts as eight
    function int unsigned dim(bit [1:0] idx);
      if (dim_reg[idx] == 4'd0) return 1;
      if (dim_reg[idx] > 4'd8) return 8;
      return dim_reg[idx];
    endfunction

    function void set_dim(bit [1:0] idx, bit [31:0] val);
      dim_reg[idx] = val[3:0];
    endfunction

    function int pending();
      return exp_q.size();
    endfunction

    function void note_item(bit [1:0] op, bit [2:0] r, bit [2:0] c, bit [31:0] v);
      int unsigned nr, ni, nc, half;
      bit [31:0]   s;
      product_t    e;
      if (op == OP_LOAD_A) begin
        a_mem[{r, c}] = v;
      end else if (op == OP_LOAD_B) begin
        b_mem[{r, c}] = v;
      end else if (op == OP_COMPUTE) begin
        nr   = dim(REG_ROW_COUNT);
        ni   = dim(REG_INNER_COUNT);
        nc   = dim(REG_COL_COUNT);
        half = ni / 2;
        // row and column factors from pairwise products
        for (int i = 0; i < nr; i++) begin
          s = 0;
          for (int k = 0; k < half; k++)
            s = s + a_mem[i*8 + 2*k] * a_mem[i*8 + 2*k + 1];
          row_fac[i] = s;
        end
        for (int j = 0; j < nc; j++) begin
          s = 0;
          for (int k = 0; k < half; k++)
            s = s + b_mem[(2*k)*8 + j] * b_mem[(2*k + 1)*8 + j];
          col_fac[j] = s;
        end
        // product elements, row-major, odd inner term added once
        for (int i = 0; i < nr; i++) begin
          for (int j = 0; j < nc; j++) begin
            s = 32'd0 - row_fac[i] - col_fac[j];
            for (int k = 0; k < half; k++)
              s = s + (a_mem[i*8 + 2*k] + b_mem[(2*k + 1)*8 + j]) *
                      (a_mem[i*8 + 2*k + 1] + b_mem[(2*k)*8 + j]);
            if (ni % 2 == 1)
              s = s + a_mem[i*8 + ni - 1] * b_mem[(ni - 1)*8 + j];
            e.r    = 3'(i);
            e.c    = 3'(j);
            e.v    = s;
            e.last = (i == nr - 1) && (j == nc - 1);
            exp_q.push_back(e);
          end
        end
      end
    endfunction

    function void check_product(bit [2:0] r, bit [2:0] c, bit [31:0] v, bit last);
      product_t e;
      if (exp_q.size() == 0) begin
        $error("unexpected product element: out_row %0d out_col %0d result %h", r, c, v);
        errors++;
        return;
      end
      e = exp_q.pop_front();
      checked++;
      if (r != e.r) begin
        $error("out_row: expected %0d, actual %0d", e.r, r);
        errors++;
      end
      if (c != e.c) begin
        $error("out_col: expected %0d, actual %0d", e.c, c);
        errors++;
      end
      if (v != e.v) begin
        $error("result (%0d,%0d): expected %h, actual %h", e.r, e.c, e.v, v);
        errors++;
      end
      if (last != e.last) begin
        $error("last (%0d,%0d): expected %0d, actual %0d", e.r, e.c, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // op[1:0], row[4:2], col[7:5], value[39:8]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // out_row[2:0], out_col[5:3], result[37:6], zero fill
  logic        m_axis_tlast;   // last
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  wmm_scoreboard sb = new();

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_req;
  int          n_items;
  int          n_computes;
  int          n_reg_writes;
  bit          a_done [64];
  bit          b_done [64];

  winograd_matrix_multiply u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // element value, biased towards the extremes
  function automatic bit [31:0] rand_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // dimension register value, mostly small, sometimes out of range
  function automatic bit [3:0] pick_dim();
    case ($urandom_range(9))
      0: return 4'd0;
      1: return 4'($urandom_range(15, 9));
      2: return 4'd8;
      default: return 4'($urandom_range(4, 1));
    endcase
  endfunction

  // one input transfer, with random idle cycles in front
  task automatic send_item(bit [1:0] op, bit [2:0] r, bit [2:0] c, bit [31:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {v, c, r, op};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(op, r, c, v);
    if (op == OP_LOAD_A) a_done[{r, c}] = 1'b1;
    if (op == OP_LOAD_B) b_done[{r, c}] = 1'b1;
    if (op == OP_COMPUTE) n_computes++;
    if (op != OP_UNUSED) n_items++;
  endtask

  task automatic compute_item();
    send_item(OP_COMPUTE, 3'($urandom()), 3'($urandom()), $urandom());
  endtask

  // drop valid, let every product drain, then allow the sequencer to settle
  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic apb_write(bit [1:0] idx, bit [3:0] val);
    bit [31:0] w;
    w      = $urandom();
    w[3:0] = val;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= w;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_dim(idx, w);
    n_reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_dims(bit [3:0] rows, bit [3:0] inner, bit [3:0] cols);
    wait_drained();
    apb_write(REG_ROW_COUNT, rows);
    apb_write(REG_INNER_COUNT, inner);
    apb_write(REG_COL_COUNT, cols);
  endtask

  // write every element the next compute reads that is still unwritten
  task automatic ensure_loaded();
    int unsigned nr, ni, nc;
    nr = sb.dim(REG_ROW_COUNT);
    ni = sb.dim(REG_INNER_COUNT);
    nc = sb.dim(REG_COL_COUNT);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < ni; k++)
        if (!a_done[i*8 + k]) send_item(OP_LOAD_A, 3'(i), 3'(k), rand_value());
    for (int k = 0; k < ni; k++)
      for (int j = 0; j < nc; j++)
        if (!b_done[k*8 + j]) send_item(OP_LOAD_B, 3'(k), 3'(j), rand_value());
  endtask

  // a random load, half the time inside the active region, or an ignored item
  task automatic random_load();
    bit [1:0] op;
    bit [2:0] r, c;
    int unsigned nr, ni, nc;
    nr = sb.dim(REG_ROW_COUNT);
    ni = sb.dim(REG_INNER_COUNT);
    nc = sb.dim(REG_COL_COUNT);
    if ($urandom_range(9) == 0) begin
      send_item(OP_UNUSED, 3'($urandom()), 3'($urandom()), $urandom());
    end else begin
      op = $urandom_range(1) ? OP_LOAD_A : OP_LOAD_B;
      if ($urandom_range(1)) begin
        r = 3'($urandom());
        c = 3'($urandom());
      end else if (op == OP_LOAD_A) begin
        r = 3'($urandom_range(nr - 1));
        c = 3'($urandom_range(ni - 1));
      end else begin
        r = 3'($urandom_range(ni - 1));
        c = 3'($urandom_range(nc - 1));
      end
      send_item(op, r, c, rand_value());
    end
  endtask

  task automatic run_phase(int target);
    bit first;
    first = 1'b1;
    while (n_items < target) begin
      if (first || $urandom_range(2) == 0) set_dims(pick_dim(), pick_dim(), pick_dim());
      first = 1'b0;
      ensure_loaded();
      repeat ($urandom_range(6)) random_load();
      compute_item();
      if ($urandom_range(3) == 0) compute_item();
    end
  endtask

  // receiver: random back-pressure plus a long hold-off when requested
  initial begin
    int hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_product(m_axis_tdata[2:0], m_axis_tdata[5:3], m_axis_tdata[37:6],
                       m_axis_tlast);
  end

  // watchdog: ends the run after too long without any transfer
  initial begin
    int idle_cnt;
    idle_cnt = 0;
    @(negedge rst);
    while (idle_cnt < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
        idle_cnt = 0;
      else
        idle_cnt++;
    end
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // main sequence
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_req      = 1'b0;
    n_items       = 0;
    n_computes    = 0;
    n_reg_writes  = 0;
    tx_idle_pct   = 8;
    rx_idle_pct   = 84;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // smallest product, single odd term and no pairs
    set_dims(4'd1, 4'd1, 4'd1);
    send_item(OP_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send_item(OP_LOAD_B, 3'd0, 3'd0, 32'h8000_0000);
    compute_item();
    send_item(OP_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);

    // one pair, extreme values everywhere
    set_dims(4'd2, 4'd2, 4'd2);
    send_item(OP_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF);
    send_item(OP_LOAD_A, 3'd0, 3'd1, 32'h8000_0000);
    send_item(OP_LOAD_A, 3'd1, 3'd0, 32'h7FFF_FFFF);
    send_item(OP_LOAD_A, 3'd1, 3'd1, 32'h0000_0000);
    send_item(OP_LOAD_B, 3'd0, 3'd0, 32'h8000_0000);
    send_item(OP_LOAD_B, 3'd0, 3'd1, 32'hFFFF_FFFF);
    send_item(OP_LOAD_B, 3'd1, 3'd0, 32'h0000_0000);
    send_item(OP_LOAD_B, 3'd1, 3'd1, 32'h7FFF_FFFF);
    compute_item();

    // zero row count acts as one; odd inner count with a pair plus correction
    set_dims(4'd0, 4'd3, 4'd1);
    send_item(OP_LOAD_A, 3'd0, 3'd2, 32'h8000_0000);
    send_item(OP_LOAD_B, 3'd2, 3'd0, 32'h8000_0000);
    compute_item();
    send_item(OP_LOAD_A, 3'd7, 3'd7, 32'h0000_0000);
    send_item(OP_LOAD_B, 3'd7, 3'd7, 32'hFFFF_FFFF);

    run_phase(140);

    tx_idle_pct = 84;
    rx_idle_pct = 8;
    run_phase(260);

    // full size, receiver held off while the sender keeps offering items
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_dims(4'd15, 4'd8, 4'd9);
    ensure_loaded();
    hold_req = 1'b1;
    compute_item();
    repeat (4) random_load();
    compute_item();
    run_phase(380);

    wait_drained();
    repeat (30) @(posedge clk);

    $display("covered %0d load/compute items, %0d computes, %0d register writes",
             n_items, n_computes, n_reg_writes);
    $display("checked %0d product elements, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
